FILE: rtl/rsa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsa_pkg - shared types and constants of the request slot ID allocator
// Operation and status codes, field widths and controller/datapath links.
// ----------------------------------------------------------------------------
package rsa_pkg;

  // Default number of request slots
  localparam int SlotsDef = 64;

  // Fixed field widths of the stream payloads
  localparam int ModeW     = 2;
  localparam int SlotIdxW  = 8;
  localparam int OpcodeW   = 8;
  localparam int StreamW   = 2;
  localparam int StatusW   = 2;
  localparam int GrantW    = 6;
  localparam int FreeCntW  = 7;
  localparam int InDataW   = 24;
  localparam int OutDataW  = 24;

  // Operation requested by an input transaction
  typedef enum logic [ModeW-1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_READ    = 2'd1,
    MODE_RELEASE = 2'd2,
    MODE_NOP     = 2'd3
  } mode_e;

  // Result status of an output transaction
  typedef enum logic [StatusW-1:0] {
    STS_OK        = 2'd0,
    STS_NO_FREE   = 2'd1,
    STS_BAD_INDEX = 2'd2,
    STS_ALL_FREE  = 2'd3
  } status_e;

  // Controller to datapath commands
  typedef struct packed {
    logic clear;   // init sweep writes one entry
    logic load;    // capture input transaction
    logic commit;  // update state and load output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;  // sweep is at its last entry
    logic out_free;    // output register can take a result
  } sts_t;

endpackage : rsa_pkg
`default_nettype wire

FILE: rtl/rsa_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsa_datapath - free stack, slot tables and result register
// Holds the LIFO free-index stack, the per-slot opcode/stream tables, the
// free level and the output register; acts on commands from the controller.
// ----------------------------------------------------------------------------
module rsa_datapath
  import rsa_pkg::*;
#(
  parameter int SLOTS = SlotsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cmd_t                 cmd_i,
  output      sts_t                 sts_o,
  // input payload
  input  wire logic [InDataW-1:0]   in_data_i,   // slot_index, request_opcode, stream_mode
  input  wire logic [ModeW-1:0]     in_user_i,   // mode
  // result channel
  output      logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output      logic [OutDataW-1:0]  m_axis_tdata,  // granted_index, slot_opcode,
                                                   // slot_stream_mode, free_count
  output      logic [StatusW-1:0]   m_axis_tuser   // status
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LVL_W = $clog2(SLOTS + 1);
  localparam int CMP_W = (LVL_W > SlotIdxW) ? LVL_W : SlotIdxW;

  // Captured input transaction
  mode_e                mode_q;
  logic [SlotIdxW-1:0]  sidx_q;
  logic [OpcodeW-1:0]   opc_q;
  logic [StreamW-1:0]   smode_q;

  // Control state
  logic [LVL_W-1:0]     level_q, level_d;
  logic [IDX_W-1:0]     clr_addr_q;
  logic                 out_valid_q;

  // Memories and their registered read data
  logic [IDX_W-1:0]     stack_mem [SLOTS];
  logic [OpcodeW-1:0]   opc_mem   [SLOTS];
  logic [StreamW-1:0]   smode_mem [SLOTS];
  logic [IDX_W-1:0]     stack_rd_q;
  logic [OpcodeW-1:0]   opc_rd_q;
  logic [StreamW-1:0]   smode_rd_q;

  // Output register
  status_e              out_status_q, res_status;
  logic [GrantW-1:0]    out_idx_q;
  logic [OpcodeW-1:0]   out_opc_q;
  logic [StreamW-1:0]   out_smode_q;
  logic [FreeCntW-1:0]  out_free_q;

  // Result and write-port signals
  logic [IDX_W-1:0]     res_idx;
  logic [OpcodeW-1:0]   res_opc;
  logic [StreamW-1:0]   res_smode;
  logic [IDX_W-1:0]     slot_addr;
  logic [IDX_W-1:0]     pop_addr;
  logic [IDX_W-1:0]     push_addr;
  logic                 idx_ok;
  logic                 stk_we, opc_we, smode_we;
  logic [IDX_W-1:0]     stk_wa, opc_wa, smode_wa, stk_wd;
  logic [OpcodeW-1:0]   opc_wd;
  logic [StreamW-1:0]   smode_wd;

  // Capture input transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sidx_q  <= in_data_i[7:0];
      opc_q   <= in_data_i[15:8];
      smode_q <= in_data_i[17:16];
      mode_q  <= mode_e'(in_user_i);
    end
  end

  // Address decode
  assign slot_addr = IDX_W'(sidx_q[SlotIdxW-2:0]);
  assign pop_addr  = IDX_W'(level_q - LVL_W'(1));
  assign push_addr = IDX_W'(level_q);
  assign idx_ok    = !sidx_q[SlotIdxW-1] &&
                     (CMP_W'(sidx_q[SlotIdxW-2:0]) < CMP_W'(SLOTS));

  // Memory reads, one registered port each
  always_ff @(posedge clk_i) begin
    stack_rd_q <= stack_mem[pop_addr];
    opc_rd_q   <= opc_mem[slot_addr];
    smode_rd_q <= smode_mem[slot_addr];
  end

  // Operation result and state update
  always_comb begin
    res_status = STS_OK;
    res_idx    = '0;
    res_opc    = '0;
    res_smode  = '0;
    level_d    = level_q;
    stk_we     = 1'b0;
    stk_wa     = push_addr;
    stk_wd     = slot_addr;
    opc_we     = 1'b0;
    opc_wa     = slot_addr;
    opc_wd     = '0;
    smode_we   = 1'b0;
    smode_wa   = stack_rd_q;
    smode_wd   = smode_q;
    unique case (mode_q)
      MODE_ALLOC: begin
        if (level_q == '0) begin
          res_status = STS_NO_FREE;
        end else begin
          res_idx  = stack_rd_q;
          level_d  = level_q - LVL_W'(1);
          opc_we   = 1'b1;
          opc_wa   = stack_rd_q;
          opc_wd   = opc_q;
          smode_we = 1'b1;
        end
      end
      MODE_READ: begin
        if (!idx_ok) begin
          res_status = STS_BAD_INDEX;
        end else begin
          res_idx   = slot_addr;
          res_opc   = opc_rd_q;
          res_smode = smode_rd_q;
        end
      end
      MODE_RELEASE: begin
        if (!idx_ok) begin
          res_status = STS_BAD_INDEX;
        end else if (level_q == LVL_W'(SLOTS)) begin
          res_status = STS_ALL_FREE;
        end else begin
          res_idx = slot_addr;
          level_d = level_q + LVL_W'(1);
          stk_we  = 1'b1;
          opc_we  = 1'b1;
        end
      end
      MODE_NOP: begin
        res_status = STS_OK;
      end
      default: begin
        res_status = STS_OK;
      end
    endcase
    // init sweep overrides every write port
    if (cmd_i.clear) begin
      stk_we   = 1'b1;
      stk_wa   = clr_addr_q;
      stk_wd   = clr_addr_q;
      opc_we   = 1'b1;
      opc_wa   = clr_addr_q;
      opc_wd   = '0;
      smode_we = 1'b1;
      smode_wa = clr_addr_q;
      smode_wd = '0;
    end else if (!cmd_i.commit) begin
      stk_we   = 1'b0;
      opc_we   = 1'b0;
      smode_we = 1'b0;
    end
  end

  // Memory writes
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stack_mem[stk_wa] <= stk_wd;
    end
    if (opc_we) begin
      opc_mem[opc_wa] <= opc_wd;
    end
    if (smode_we) begin
      smode_mem[smode_wa] <= smode_wd;
    end
  end

  // Free level and init sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q    <= LVL_W'(SLOTS);
      clr_addr_q <= '0;
    end else begin
      if (cmd_i.commit) begin
        level_q <= level_d;
      end
      if (cmd_i.clear) begin
        clr_addr_q <= clr_addr_q + IDX_W'(1);
      end
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_status_q <= res_status;
      out_idx_q    <= GrantW'(res_idx);
      out_opc_q    <= res_opc;
      out_smode_q  <= res_smode;
      out_free_q   <= FreeCntW'(level_d);
    end
  end

  assign sts_o.clear_last = (clr_addr_q == IDX_W'(SLOTS - 1));
  assign sts_o.out_free   = !out_valid_q || m_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {1'b0, out_free_q, out_smode_q, out_opc_q, out_idx_q};

  // Free level never exceeds the slot count
  a_level_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LVL_W'(SLOTS))
    else $error("free level above slot count");

  // A pending result is never overwritten
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.commit && out_valid_q && !m_axis_tready))
    else $error("result register overwritten");

  // Successful allocate pops exactly one entry
  a_alloc_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && mode_q == MODE_ALLOC && level_q != '0)
      |=> level_q == $past(level_q) - LVL_W'(1))
    else $error("allocate did not pop one entry");

  // Init sweep never overlaps a capture or a commit
  a_clear_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.clear && (cmd_i.commit || cmd_i.load)))
    else $error("transaction during init sweep");

endmodule : rsa_datapath
`default_nettype wire

FILE: rtl/rsa_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsa_ctrl - sequencing controller of the request slot ID allocator
// Runs the init sweep after reset, then steps each transaction through
// capture, memory read and commit.
// ----------------------------------------------------------------------------
module rsa_ctrl
  import rsa_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output      logic in_ready_o,
  input  wire sts_t sts_i,
  output      cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_DONE
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   accept;

  assign accept = in_valid_i && in_ready_q;

  // State and registered ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      in_ready_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_CLEAR: begin
          if (sts_i.clear_last) begin
            state_q    <= ST_IDLE;
            in_ready_q <= 1'b1;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state_q    <= ST_EXEC;
            in_ready_q <= 1'b0;
          end
        end
        // memory read in flight
        ST_EXEC: begin
          state_q <= ST_DONE;
        end
        // wait for a free result slot, then commit
        ST_DONE: begin
          if (sts_i.out_free) begin
            state_q    <= ST_IDLE;
            in_ready_q <= 1'b1;
          end
        end
        default: begin
          state_q    <= ST_CLEAR;
          in_ready_q <= 1'b0;
        end
      endcase
    end
  end

  assign in_ready_o   = in_ready_q;
  assign cmd_o.clear  = (state_q == ST_CLEAR);
  assign cmd_o.load   = accept;
  assign cmd_o.commit = (state_q == ST_DONE) && sts_i.out_free;

  // Ready is only offered in the idle state
  a_ready_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_q |-> state_q == ST_IDLE)
    else $error("ready outside idle");

  // Every accepted transaction passes through the exec state and then the done state
  a_accept_seq : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_EXEC ##1 state_q == ST_DONE)
    else $error("accepted transaction skipped a stage");

  // Commit returns to idle with ready raised
  a_commit_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> in_ready_q)
    else $error("ready not restored after commit");

endmodule : rsa_ctrl
`default_nettype wire

FILE: rtl/request_slot_id_allocator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// request_slot_id_allocator_core - request slot ID allocator
// Hands out slot IDs from a LIFO free-index stack and keeps an opcode and a
// stream strategy per slot.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one operation per transaction: tuser selects allocate,
//   read, release or no-op; tdata carries slot index, opcode and stream mode.
//   m_axis returns exactly one result per operation, in order: tuser holds
//   the status, tdata the granted/read index, stored fields and free count.
// Timing:
//   The block takes one operation at a time through capture, a registered
//   memory read, then commit of stack, tables and level, with s_axis_tready
//   low until commit; m_axis_tvalid is set by that commit. The result
//   sits in an output register, so the next operation is
//   accepted while it waits; a receiver stall holds that operation at its
//   commit step until the output register frees up.
// Reset:
//   After reset an init sweep writes stack entry i with i
//   and zeroes both slot tables; s_axis_tready stays low until it ends.
//   All SLOTS slots are then free; the first allocate grants SLOTS-1.
// ----------------------------------------------------------------------------
module request_slot_id_allocator_core
  import rsa_pkg::*;
#(
  parameter int SLOTS = SlotsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // operation channel
  input  wire logic                 s_axis_tvalid,
  output      logic                 s_axis_tready,
  input  wire logic [InDataW-1:0]   s_axis_tdata,  // slot_index, request_opcode,
                                                   // stream_mode
  input  wire logic [ModeW-1:0]     s_axis_tuser,  // mode
  // result channel
  output      logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output      logic [OutDataW-1:0]  m_axis_tdata,  // granted_index, slot_opcode,
                                                   // slot_stream_mode, free_count
  output      logic [StatusW-1:0]   m_axis_tuser   // status
);

  cmd_t cmd;
  sts_t sts;

  // Sequencing
  rsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Stack, tables and result register
  rsa_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_data_i     (s_axis_tdata),
    .in_user_i     (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule : request_slot_id_allocator_core
`default_nettype wire
